// ===== src/pfsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsp_pkg
// Shared constants and types for the frame FIFO packer.
// ----------------------------------------------------------------------------
package pfsp_pkg;

  localparam int QueueDepth   = 16384;
  localparam int ChannelCount = 4;
  localparam int SlotW        = $clog2(QueueDepth);
  localparam int PtrW         = SlotW + 1;
  localparam int SampleW      = 24;
  localparam int CountW       = 15;

  localparam logic [1:0] CMD_RESERVE = 2'd0;
  localparam logic [1:0] CMD_PUSH    = 2'd1;
  localparam logic [1:0] CMD_POP     = 2'd2;
  localparam logic [1:0] CMD_FLUSH   = 2'd3;

  localparam logic [1:0] FMT_F32 = 2'd0;
  localparam logic [1:0] FMT_S24 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;
  localparam logic [1:0] FMT_BAD = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_BAD_FMT  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_SEQ_ERR  = 3'd4;

  typedef logic [ChannelCount*SampleW-1:0] frame_t;

  // Result header carried alongside the memory read.
  typedef struct packed {
    logic [2:0]        status;
    logic              given;
    logic [CountW-1:0] avail;
  } result_t;

endpackage

// ===== src/pfsp_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsp_conv
// One-channel sample converter to signed 24-bit.
// ----------------------------------------------------------------------------
module pfsp_conv (
  input  logic [1:0]  fmt,
  input  logic [31:0] word,
  output logic [23:0] sample
);

  logic [7:0]  ex;
  logic [23:0] man;
  logic [47:0] prod;
  logic [47:0] sh;
  logic [23:0] ip;
  logic        rb;
  logic        st;
  logic [23:0] mag;
  logic [23:0] fl;
  logic [5:0]  rs;

  // |v| < 1: v = man * 2^(ex-150); scaled = man*8388607*2^(ex-150), rounded
  // once to 24 bits in float, then to an integer (both nearest-even).
  logic [47:0] p2;
  logic [5:0]  lz;
  logic [23:0] fm;
  logic        g1, s1;
  logic [24:0] fr;
  logic [8:0]  e2;
  always_comb begin
    rs = 6'd0;
    sh = 48'd0;
    ip = 24'd0;
    rb = 1'b0;
    st = 1'b0;
    ex   = word[30:23];
    man  = {ex != 8'd0, word[22:0]};
    prod = 48'(man) * 48'd8388607;
    lz = 6'd0;
    for (int i = 47; i >= 0; i--) begin
      if (prod[i] && lz == 6'd0) lz = 6'(48 - i);
    end
    p2 = (lz == 6'd0) ? 48'd0 : prod << (lz - 6'd1);
    fm = p2[47:24];
    g1 = p2[23];
    s1 = |p2[22:0];
    fr = {1'b0, fm} + 25'(g1 && (s1 || fm[0]));
    // value = fm * 2^(ex-125-lz), kept as fm * 2^(e2-149)
    e2 = 9'(ex) + 9'd24 - 9'(lz);
    if (fr[24]) begin
      fr = fr >> 1;
      e2 = e2 + 9'd1;
    end
    // value = fr[23:0] * 2^(e2-126-23) ; integer part shift = 149-e2
    mag = 24'd0;
    if (e2 >= 9'd126 && e2 < 9'd149) begin
      rs = 6'(9'd149 - e2);
      sh = {fr[23:0], 24'd0} >> rs;
      ip = sh[47:24];
      rb = sh[23];
      st = |sh[22:0];
      mag = ip + 24'(rb && (st || ip[0]));
    end else if (e2 == 9'd125) begin
      mag = 24'(fr[23:0] > 24'h800000);
    end
    if (ex == 8'hFF && word[22:0] != 23'd0) fl = 24'd0;
    else if (ex >= 8'd127) fl = word[31] ? 24'h800001 : 24'h7FFFFF;
    else if (lz == 6'd0) fl = 24'd0;
    else fl = word[31] ? (24'd0 - mag) : mag;
    case (fmt)
      pfsp_pkg::FMT_F32: sample = fl;
      pfsp_pkg::FMT_S24: sample = word[23:0];
      default:           sample = word[31:8];
    endcase
  end

endmodule

// ===== src/pfsp_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsp_store
// Frame memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfsp_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [pfsp_pkg::SlotW-1:0]   waddr,
  input  pfsp_pkg::frame_t             wdata,
  input  logic                         re,
  input  logic [pfsp_pkg::SlotW-1:0]   raddr,
  output pfsp_pkg::frame_t             rdata
);

  pfsp_pkg::frame_t mem [pfsp_pkg::QueueDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== src/pcm_frame_fifo_s24_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_frame_fifo_s24_packer
// Four-channel frame FIFO with batch commit and conversion to signed 24-bit.
// ----------------------------------------------------------------------------
// Channel   Dir  Bits  Content
// s_axis    in   152   cmd, frame_count, in_sample0..3
// m_axis    out  120   status, frame_given, out_sample0..3, frames_available
// cfg       in   2     sample_format
//
// One request per cycle. Control and conversion are combinational in front
// of the pointer registers and the memory; the result of a request accepted
// at one edge is on m_axis from the next cycle (header register plus the
// memory read register). Reset clears pointers and the format, the memory
// keeps its contents. While a result waits on m_axis, s_axis_tready is low.
// ----------------------------------------------------------------------------
module pcm_frame_fifo_s24_packer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[1:0], frame_count[16:2], in_sample0..3 [48:17]..[144:113], pad
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], frame_given[3], out_sample0..3 [27:4]..[99:76],
  // frames_available[114:100], pad
  output logic [119:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data
);

  localparam int PW = pfsp_pkg::PtrW;
  localparam int SW = pfsp_pkg::SlotW;
  localparam int CW = pfsp_pkg::CountW;
  localparam logic [PW:0] Span = (PW+1)'(2 * pfsp_pkg::QueueDepth);

  logic [1:0]    fmt;
  logic [PW-1:0] rd, cw, pw;
  logic [CW-1:0] rem;

  // output stage
  logic                 ov;
  pfsp_pkg::result_t    ohdr;
  pfsp_pkg::frame_t     rdata;
  logic                 adv;

  assign adv           = !ov || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready     = 1'b1;

  logic [1:0]    cmd;
  logic [CW-1:0] cnt;
  assign cmd = s_axis_tdata[1:0];
  assign cnt = s_axis_tdata[16:2];

  pfsp_pkg::frame_t conv;
  for (genvar c = 0; c < pfsp_pkg::ChannelCount; c++) begin : g_ch
    pfsp_conv u_conv (
      .fmt   (fmt),
      .word  (s_axis_tdata[17+32*c +: 32]),
      .sample(conv[24*c +: 24])
    );
  end

  function automatic logic [PW-1:0] fill(input logic [PW-1:0] w, input logic [PW-1:0] r);
    fill = PW'(({1'b0, w} + Span - {1'b0, r}) & (Span - 1'b1));
  endfunction

  logic          acc;
  logic [PW-1:0] rd_next, cw_next, pw_next;
  logic [CW-1:0] rem_next;
  logic          we, re;
  pfsp_pkg::result_t hdr;
  logic [PW:0]   freec;

  assign acc = s_axis_tvalid && adv;

  always_comb begin
    rd_next = rd; cw_next = cw; pw_next = pw; rem_next = rem;
    we = 1'b0; re = 1'b0;
    hdr.status = pfsp_pkg::ST_OK;
    hdr.given  = 1'b0;
    freec = (PW+1)'(pfsp_pkg::QueueDepth) - {1'b0, fill(pw, rd)};
    unique case (cmd)
      pfsp_pkg::CMD_RESERVE: begin
        if (fmt == pfsp_pkg::FMT_BAD) hdr.status = pfsp_pkg::ST_BAD_FMT;
        else if (rem != '0) hdr.status = pfsp_pkg::ST_SEQ_ERR;
        else if ((PW+1)'(cnt) > freec) hdr.status = pfsp_pkg::ST_NO_SPACE;
        else rem_next = cnt;
      end
      pfsp_pkg::CMD_PUSH: begin
        if (rem == '0) hdr.status = pfsp_pkg::ST_SEQ_ERR;
        else if (fmt == pfsp_pkg::FMT_BAD) begin
          hdr.status = pfsp_pkg::ST_BAD_FMT;
          pw_next = cw; rem_next = '0;
        end else begin
          we = acc;
          pw_next = pw + 1'b1;
          rem_next = rem - 1'b1;
          if (rem == CW'(1)) cw_next = pw + 1'b1;
        end
      end
      pfsp_pkg::CMD_POP: begin
        if (cw == rd) hdr.status = pfsp_pkg::ST_EMPTY;
        else begin
          hdr.given = 1'b1;
          re = acc;
          rd_next = rd + 1'b1;
        end
      end
      default: begin
        rd_next = '0; cw_next = '0; pw_next = '0; rem_next = '0;
      end
    endcase
    hdr.avail = CW'(fill(cw_next, rd_next));
  end

  pfsp_store u_store (
    .clk  (clk),
    .we   (we),
    .waddr(pw[SW-1:0]),
    .wdata(conv),
    .re   (re),
    .raddr(rd[SW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= pfsp_pkg::FMT_F32;
      rd <= '0; cw <= '0; pw <= '0; rem <= '0;
      ov <= 1'b0;
    end else begin
      if (cfg_valid) fmt <= cfg_data;
      if (acc) begin
        rd <= rd_next; cw <= cw_next; pw <= pw_next; rem <= rem_next;
      end
      if (adv) ov <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) ohdr <= hdr;
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {5'd0, ohdr.avail,
                          ohdr.given ? rdata : pfsp_pkg::frame_t'(0),
                          ohdr.given, ohdr.status};

endmodule

// ===== tb/pcm_frame_fifo_s24_packer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_frame_fifo_s24_packer_tb
// Self-checking bench for the four-channel frame FIFO with 24-bit conversion.
// A scoreboard predicts status, popped frame and fill level for every
// accepted request and checks each result in order. The run has directed
// corner cases, then random batches under several sender/receiver idle
// patterns and all four sample formats.
// ----------------------------------------------------------------------------
module pcm_frame_fifo_s24_packer_tb;

  localparam int IdleLimit = 5000;

  // Predicted result of one request
  typedef struct {
    logic [2:0]                  status;
    logic                        given;
    logic [23:0]                 smp [4];
    logic [pfsp_pkg::CountW-1:0] avail;
  } fifo_result_t;

  // Predicts the FIFO and holds the results still owed by the block
  class s24_frame_model;
    logic [1:0]        fmt;
    logic [14:0]       rd_ptr, commit_ptr, pend_ptr, batch_left;
    logic [95:0]       frames [int];
    fifo_result_t      owed [$];
    int                errors;

    function new();
      fmt = pfsp_pkg::FMT_F32; rd_ptr = '0; commit_ptr = '0; pend_ptr = '0;
      batch_left = '0;
      errors = 0;
    endfunction

    // float32 -> s24: clamp, single-precision product, round half to even
    static function logic [23:0] f32_to_s24(logic [31:0] w);
      logic [7:0]  ex;
      logic [22:0] fr;
      logic [63:0] p, q, r, half;
      logic [23:0] mag;
      int len, k, s;
      ex = w[30:23];
      fr = w[22:0];
      if (ex == 8'hFF && fr != 0) return 24'd0;
      if (ex > 8'd127 || (ex == 8'd127 && fr != 0)) begin
        mag = 24'd8388607;
      end else begin
        p = (ex == 0 ? {41'd0, fr} : {40'd0, 1'b1, fr}) * 64'd8388607;
        len = 0;
        for (int i = 0; i < 64; i++) if (p[i]) len = i + 1;
        // product rounded to 24 significant bits
        if (len > 24) begin
          k = len - 24;
          q = p >> k;
          r = p & ((64'd1 << k) - 1);
          half = 64'd1 << (k - 1);
          if (r > half || (r == half && q[0])) q++;
          p = q << k;
        end
        s = 150 - (ex == 0 ? 1 : int'(ex));
        if (s >= 60) begin
          mag = 24'd0;
        end else begin
          q = p >> s;
          r = p & ((64'd1 << s) - 1);
          half = 64'd1 << (s - 1);
          if (r > half || (r == half && q[0])) q++;
          mag = q[23:0];
        end
      end
      return w[31] ? -mag : mag;
    endfunction

    function logic [23:0] to_s24(logic [31:0] w);
      if (fmt == pfsp_pkg::FMT_F32) return f32_to_s24(w);
      if (fmt == pfsp_pkg::FMT_S24) return w[23:0];
      return w[31:8];
    endfunction

    function void note_request(logic [1:0] cmd, logic [14:0] cnt, logic [31:0] raw [4]);
      fifo_result_t res;
      logic [14:0] used;
      res.status = pfsp_pkg::ST_OK;
      res.given = 1'b0;
      for (int c = 0; c < 4; c++) res.smp[c] = '0;
      case (cmd)
        pfsp_pkg::CMD_RESERVE: begin
          used = pend_ptr - rd_ptr;
          if (fmt == pfsp_pkg::FMT_BAD) res.status = pfsp_pkg::ST_BAD_FMT;
          else if (batch_left != 0) res.status = pfsp_pkg::ST_SEQ_ERR;
          else if (cnt > 15'(pfsp_pkg::QueueDepth) - used) res.status = pfsp_pkg::ST_NO_SPACE;
          else batch_left = cnt;
        end
        pfsp_pkg::CMD_PUSH: begin
          if (batch_left == 0) begin
            res.status = pfsp_pkg::ST_SEQ_ERR;
          end else if (fmt == pfsp_pkg::FMT_BAD) begin
            res.status = pfsp_pkg::ST_BAD_FMT;
            pend_ptr = commit_ptr;
            batch_left = '0;
          end else begin
            frames[pend_ptr[13:0]] = {to_s24(raw[3]), to_s24(raw[2]),
                                      to_s24(raw[1]), to_s24(raw[0])};
            pend_ptr++;
            batch_left--;
            if (batch_left == 0) commit_ptr = pend_ptr;
          end
        end
        pfsp_pkg::CMD_POP: begin
          if (commit_ptr == rd_ptr) begin
            res.status = pfsp_pkg::ST_EMPTY;
          end else begin
            for (int c = 0; c < 4; c++) res.smp[c] = frames[rd_ptr[13:0]][c*24 +: 24];
            res.given = 1'b1;
            rd_ptr++;
          end
        end
        default: begin
          rd_ptr = '0; commit_ptr = '0; pend_ptr = '0; batch_left = '0;
        end
      endcase
      res.avail = commit_ptr - rd_ptr;
      owed.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [119:0] d);
      fifo_result_t e;
      if (owed.size() == 0) begin
        report("unexpected result", d[31:0], 32'd0);
        return;
      end
      e = owed.pop_front();
      if (d[2:0] !== e.status) report("status", 32'(d[2:0]), 32'(e.status));
      if (d[3] !== e.given) report("frame_given", 32'(d[3]), 32'(e.given));
      for (int c = 0; c < 4; c++)
        if (d[4 + c*24 +: 24] !== e.smp[c])
          report("sample", 32'(d[4 + c*24 +: 24]), 32'(e.smp[c]));
      if (d[114:100] !== e.avail) report("frames_available", 32'(d[114:100]), 32'(e.avail));
    endtask
  endclass

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [151:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [119:0] m_axis_tdata;
  logic         cfg_valid, cfg_ready;
  logic [1:0]   cfg_data;

  s24_frame_model fifo_model = new();
  int send_idle_pct, recv_stall_pct;
  int sent, idle_cycles;

  pcm_frame_fifo_s24_packer uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver: stall pattern set per phase
  initial begin
    m_axis_tready = 1;
    forever begin
      @(negedge clk);
      m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // sample at the edge, results checked in order
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) fifo_model.check_result(m_axis_tdata);
  end

  // watchdog: no handshake of any kind for too long ends the run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request; called and returns at a falling edge
  task send_request(logic [1:0] cmd, logic [14:0] cnt, logic [31:0] raw [4]);
    s_axis_tdata = {7'd0, raw[3], raw[2], raw[1], raw[0], cnt, cmd};
    s_axis_tvalid = 1;
    do @(posedge clk); while (!s_axis_tready);
    fifo_model.note_request(cmd, cnt, raw);
    sent++;
    @(negedge clk);
    s_axis_tvalid = 0;
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
  endtask

  task send_cmd(logic [1:0] cmd, logic [14:0] cnt);
    logic [31:0] raw [4];
    for (int c = 0; c < 4; c++) raw[c] = $urandom;
    send_request(cmd, cnt, raw);
  endtask

  // wait until every owed result has been checked
  task drain();
    while (fifo_model.owed.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_format(logic [1:0] f);
    drain();
    cfg_data = f;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    fifo_model.fmt = f;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // raw word biased toward float corner values
  function logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h7FC00000 | $urandom_range(0, 1);  // NaN
      1: return $urandom_range(0, 1) ? 32'h7F800000 : 32'hFF800000;  // inf
      2: return $urandom_range(0, 1) ? 32'h3F800000 : 32'hBF800000;  // +/-1
      3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'd127, 23'($urandom)};  // past clamp
      4: return {1'b0, 8'd0, 23'($urandom)};  // denormal
      5: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'($urandom_range(100, 126)),
                 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task push_frame();
    logic [31:0] raw [4];
    for (int c = 0; c < 4; c++) raw[c] = pick_word();
    send_request(pfsp_pkg::CMD_PUSH, 15'($urandom), raw);
  endtask

  task random_part(int n);
    int stop, len;
    stop = sent + n;
    while (sent < stop) begin
      case ($urandom_range(0, 99)) inside
        [0:69]: begin
          len = $urandom_range(1, 6);
          send_cmd(pfsp_pkg::CMD_RESERVE, 15'(len));
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_cmd(pfsp_pkg::CMD_POP, 15'd0);
            push_frame();
          end
          len = $urandom_range(0, len + 1);
          for (int i = 0; i < len; i++) send_cmd(pfsp_pkg::CMD_POP, 15'($urandom));
        end
        [70:84]: begin
          if ($urandom_range(0, 1)) push_frame();
          else send_cmd(2'($urandom), $urandom_range(0, 1) ? 15'($urandom_range(0, 16384))
                                                            : 15'($urandom_range(0, 8)));
        end
        [85:92]: send_cmd(pfsp_pkg::CMD_FLUSH, 15'($urandom));
        default: drain();  // sender holds until every owed result is back
      endcase
    end
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_valid = 0;
    cfg_data = pfsp_pkg::FMT_F32;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed corners in float format
    send_cmd(pfsp_pkg::CMD_POP, 15'd0);             // empty
    push_frame();                                   // no open batch
    send_cmd(pfsp_pkg::CMD_RESERVE, 15'd0);         // zero frames
    send_cmd(pfsp_pkg::CMD_RESERVE, 15'd16384);     // whole queue
    send_cmd(pfsp_pkg::CMD_RESERVE, 15'd1);         // batch already open
    send_cmd(pfsp_pkg::CMD_FLUSH, 15'd0);
    send_cmd(pfsp_pkg::CMD_RESERVE, 15'd3);
    for (int i = 0; i < 3; i++) push_frame();
    send_cmd(pfsp_pkg::CMD_RESERVE, 15'd16384);     // no room
    send_cmd(pfsp_pkg::CMD_RESERVE, 15'd2);
    push_frame();
    for (int i = 0; i < 4; i++) send_cmd(pfsp_pkg::CMD_POP, 15'd0);  // uncommitted stays hidden
    push_frame();
    send_cmd(pfsp_pkg::CMD_POP, 15'd0);
    send_cmd(pfsp_pkg::CMD_RESERVE, 15'd2);
    push_frame();                                   // batch left open for the bad format

    write_format(pfsp_pkg::FMT_BAD);
    push_frame();                                   // discards open batch
    send_cmd(pfsp_pkg::CMD_RESERVE, 15'd1);         // bad format
    send_cmd(pfsp_pkg::CMD_POP, 15'd0);

    for (int ph = 0; ph < 5; ph++) begin
      write_format(ph == 4 ? pfsp_pkg::FMT_F32 : 2'(ph));
      send_idle_pct  = (ph % 4 == 1) ? 74 : (ph % 4 == 3) ? 17 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 74 : (ph % 4 == 3) ? 17 : 0;
      random_part(ph == 3 ? 80 : 140);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fifo_model.errors == 0 && fifo_model.owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
